FILE: rtl/column_texel_remap_pixel_defines.svh
// assertion macros shared by the column texel remap pixel rtl
`ifndef COLUMN_TEXEL_REMAP_PIXEL_DEFINES_SVH
`define COLUMN_TEXEL_REMAP_PIXEL_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define CTRP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define CTRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ctrp_pkg.sv
// package with the constants, item types and helpers of the column texel remap pixel block
`default_nettype none

package ctrp_pkg;

   localparam int SCREEN_WIDTH   = 320;
   localparam int SCREEN_HEIGHT  = 200;
   localparam int TEXTURE_HEIGHT = 128;
   localparam int FRACTION_BITS  = 16;
   localparam int TEXEL_BITS     = (TEXTURE_HEIGHT > 1) ? $clog2(TEXTURE_HEIGHT) : 1;
   localparam int TABLE_DEPTH    = 256;

   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_TEXEL = 2'd1;
   localparam logic [1:0] OP_TRANS = 2'd2;
   localparam logic [1:0] OP_CMAP  = 2'd3;

   localparam logic [7:0] CENTER_ROW_RESET = 8'd100;

   typedef struct packed {
      logic [1:0]         operation;
      logic [8:0]         screen_column;
      logic [7:0]         screen_row;
      logic signed [31:0] texture_mid;
      logic signed [31:0] inverse_scale;
      logic               low_detail;
      logic [7:0]         table_index;
      logic [7:0]         table_data;
   } req_type;

   typedef struct packed {
      logic [8:0] pixel_column;
      logic [7:0] pixel_row;
      logic [7:0] pixel_color;
      logic       double_width;
      logic       range_error;
   } rsp_type;

   // item handed from the coordinate pipe to the table lookups
   typedef struct packed {
      logic [1:0]            operation;
      logic [8:0]            column;
      logic [7:0]            row;
      logic                  low_detail;
      logic                  range_error;
      logic [TEXEL_BITS-1:0] texel_index;
      logic [7:0]            table_index;
      logic [7:0]            table_data;
   } tex_item_type;

   // texel write address: table index wrapped to the column height
   function automatic logic [TEXEL_BITS-1:0] texel_write_addr(input logic [7:0] index);
      logic [31:0] wide;
      wide = 32'(index);
      return wide[TEXEL_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ctrp_ram.sv
// generic single-port ram with registered read
`default_nettype none

module ctrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic                            rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]        addr,
   input  wire logic [WIDTH-1:0]                wr_data,
   output logic      [WIDTH-1:0]                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ctrp_coord.sv
// coordinate pipe: range check, row offset multiply and texel index
`default_nettype none

module ctrp_coord
   import ctrp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [7:0]   center_row,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire req_type      in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output tex_item_type      out_data
);

   typedef struct packed {
      logic [1:0]         operation;
      logic [8:0]         column;
      logic [7:0]         row;
      logic               low_detail;
      logic               range_error;
      logic signed [8:0]  row_offset;
      logic signed [31:0] mid;
      logic signed [31:0] scale;
      logic [7:0]         table_index;
      logic [7:0]         table_data;
   } st1_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [8:0]  column;
      logic [7:0]  row;
      logic        low_detail;
      logic        range_error;
      logic [31:0] mid;
      logic [31:0] product;
      logic [7:0]  table_index;
      logic [7:0]  table_data;
   } st2_type;

   logic    st1_valid_ff, st1_valid_in;
   logic    st2_valid_ff, st2_valid_in;
   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   logic    st1_en, st2_en;

   logic [9:0]         x_wide;
   logic               off_screen;
   logic signed [40:0] product_full;
   logic [31:0]        frac;
   logic [31:0]        frac_int;

   assign st2_en   = !st2_valid_ff || out_ready;
   assign st1_en   = !st1_valid_ff || st2_en;
   assign in_ready = st1_en;

   // stage 1: column doubling, screen bounds and signed row offset
   always_comb begin
      x_wide     = in_data.low_detail ? {in_data.screen_column, 1'b0}
                                      : {1'b0, in_data.screen_column};
      off_screen = ({22'd0, x_wide} >= 32'(SCREEN_WIDTH)) ||
                   ({24'd0, in_data.screen_row} >= 32'(SCREEN_HEIGHT));

      st1_in.operation   = in_data.operation;
      st1_in.range_error = off_screen;
      st1_in.column      = off_screen ? 9'd0 : x_wide[8:0];
      st1_in.row         = off_screen ? 8'd0 : in_data.screen_row;
      st1_in.low_detail  = off_screen ? 1'b0 : in_data.low_detail;
      st1_in.row_offset  = $signed({1'b0, in_data.screen_row}) - $signed({1'b0, center_row});
      st1_in.mid         = in_data.texture_mid;
      st1_in.scale       = in_data.inverse_scale;
      st1_in.table_index = in_data.table_index;
      st1_in.table_data  = in_data.table_data;
      st1_valid_in       = in_valid;
   end

   // stage 2: offset times step, kept modulo 2^32
   always_comb begin
      product_full       = st1_ff.row_offset * st1_ff.scale;
      st2_in.operation   = st1_ff.operation;
      st2_in.column      = st1_ff.column;
      st2_in.row         = st1_ff.row;
      st2_in.low_detail  = st1_ff.low_detail;
      st2_in.range_error = st1_ff.range_error;
      st2_in.mid         = st1_ff.mid;
      st2_in.product     = product_full[31:0];
      st2_in.table_index = st1_ff.table_index;
      st2_in.table_data  = st1_ff.table_data;
      st2_valid_in       = st1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
      end else begin
         if (st1_en) begin
            st1_valid_ff <= st1_valid_in;
         end
         if (st2_en) begin
            st2_valid_ff <= st2_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st1_en) begin
         st1_ff <= st1_in;
      end
      if (st2_en) begin
         st2_ff <= st2_in;
      end
   end

   // texel row: integer part of the coordinate, wrapped to the column height
   always_comb begin
      frac     = st2_ff.mid + st2_ff.product;
      frac_int = $signed(frac) >>> FRACTION_BITS;

      out_data.operation   = st2_ff.operation;
      out_data.column      = st2_ff.column;
      out_data.row         = st2_ff.row;
      out_data.low_detail  = st2_ff.low_detail;
      out_data.range_error = st2_ff.range_error;
      out_data.texel_index = frac_int[TEXEL_BITS-1:0];
      out_data.table_index = st2_ff.table_index;
      out_data.table_data  = st2_ff.table_data;
   end

   assign out_valid = st2_valid_ff;

endmodule

`default_nettype wire

FILE: rtl/ctrp_lookup.sv
// table pipe: texel column, translation table and light colormap, one ram per stage
`default_nettype none

`include "column_texel_remap_pixel_defines.svh"

module ctrp_lookup
   import ctrp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire tex_item_type in_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_type           rsp_data
);

   typedef struct packed {
      logic [1:0] operation;
      logic [8:0] column;
      logic [7:0] row;
      logic       low_detail;
      logic       range_error;
      logic [7:0] table_index;
      logic [7:0] table_data;
   } pix_item_type;

   logic         st3_valid_ff, st4_valid_ff, st5_valid_ff;
   pix_item_type st3_ff, st4_ff, st5_ff;
   pix_item_type st3_in;
   logic         st3_en, st4_en, st5_en;
   logic         st4_draw;

   logic [TEXEL_BITS-1:0] texel_addr;
   logic [7:0]            trans_addr, cmap_addr;
   logic                  texel_we, trans_we, cmap_we;
   logic [7:0]            texel_rd, trans_rd, cmap_rd;

   // write items leave after the colormap stage, only draws reach the output register
   assign st4_draw = st4_ff.operation == OP_DRAW;
   assign st5_en   = !st5_valid_ff || rsp_ready;
   assign st4_en   = !st4_valid_ff || !st4_draw || st5_en;
   assign st3_en   = !st3_valid_ff || st4_en;
   assign in_ready = st3_en;

   // each table is written by its write item at the same stage where draws read it,
   // so table updates land in item order
   assign texel_addr = (in_data.operation == OP_DRAW) ? in_data.texel_index
                                                      : texel_write_addr(in_data.table_index);
   assign texel_we   = in_valid && st3_en && (in_data.operation == OP_TEXEL);

   assign trans_addr = (st3_ff.operation == OP_DRAW) ? texel_rd : st3_ff.table_index;
   assign trans_we   = st3_valid_ff && st4_en && (st3_ff.operation == OP_TRANS);

   assign cmap_addr  = st4_draw ? trans_rd : st4_ff.table_index;
   assign cmap_we    = st4_valid_ff && (st4_ff.operation == OP_CMAP);

   ctrp_ram #(.WIDTH(8), .DEPTH(TEXTURE_HEIGHT)) u_texel_ram (
      .clock   (clock),
      .wr_en   (texel_we),
      .rd_en   (st3_en),
      .addr    (texel_addr),
      .wr_data (in_data.table_data),
      .rd_data (texel_rd)
   );

   ctrp_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_trans_ram (
      .clock   (clock),
      .wr_en   (trans_we),
      .rd_en   (st4_en),
      .addr    (trans_addr),
      .wr_data (st3_ff.table_data),
      .rd_data (trans_rd)
   );

   ctrp_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_cmap_ram (
      .clock   (clock),
      .wr_en   (cmap_we),
      .rd_en   (st5_en),
      .addr    (cmap_addr),
      .wr_data (st4_ff.table_data),
      .rd_data (cmap_rd)
   );

   always_comb begin
      st3_in.operation   = in_data.operation;
      st3_in.column      = in_data.column;
      st3_in.row         = in_data.row;
      st3_in.low_detail  = in_data.low_detail;
      st3_in.range_error = in_data.range_error;
      st3_in.table_index = in_data.table_index;
      st3_in.table_data  = in_data.table_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st3_valid_ff <= 1'b0;
         st4_valid_ff <= 1'b0;
         st5_valid_ff <= 1'b0;
      end else begin
         if (st3_en) begin
            st3_valid_ff <= in_valid;
         end
         if (st4_en) begin
            st4_valid_ff <= st3_valid_ff;
         end
         if (st5_en) begin
            st5_valid_ff <= st4_valid_ff && st4_draw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st3_en) begin
         st3_ff <= st3_in;
      end
      if (st4_en) begin
         st4_ff <= st3_ff;
      end
      if (st5_en) begin
         st5_ff <= st4_ff;
      end
   end

   // off-screen pixels read nothing useful, their color is forced to zero
   always_comb begin
      rsp_data.pixel_column = st5_ff.column;
      rsp_data.pixel_row    = st5_ff.row;
      rsp_data.pixel_color  = st5_ff.range_error ? 8'd0 : cmap_rd;
      rsp_data.double_width = st5_ff.low_detail;
      rsp_data.range_error  = st5_ff.range_error;
   end

   assign rsp_valid = st5_valid_ff;

   `CTRP_ASSERT_NOW(a_write_item_drains, st4_valid_ff && !st4_draw, st4_en,
      "write item held in colormap stage")
   `CTRP_ASSERT_NEXT(a_output_held, st5_valid_ff && !rsp_ready, st5_valid_ff,
      "pending pixel dropped from output register")
   `CTRP_ASSERT_NOW(a_range_zeroed, st5_valid_ff && st5_ff.range_error,
      st5_ff.column == 9'd0 && st5_ff.row == 8'd0 && !st5_ff.low_detail,
      "off-screen pixel carries coordinates")
   `CTRP_ASSERT_NOW(a_on_screen, st5_valid_ff && !st5_ff.range_error,
      ({23'd0, st5_ff.column} < 32'(SCREEN_WIDTH)) &&
      ({24'd0, st5_ff.row} < 32'(SCREEN_HEIGHT)),
      "pixel outside screen without range error")

endmodule

`default_nettype wire

FILE: rtl/column_texel_remap_pixel.sv
// Column texture mapper with palette remap. A draw item on req_ (operation 0) gives one
// pixel of a vertical texture column; the block computes texture_mid + (row - center_row)
// * inverse_scale in 16.16 with 32-bit wrap, wraps the integer part to the texel column
// height, reads the texel and maps it through the translation table and then the light
// colormap, and returns one pixel on rsp_. Off-screen pixels come back with range_error
// set and all other fields zero. Write items (operations 1 to 3) load the texel column,
// translation table or colormap and return nothing; all three tables power up undefined
// and must be written before a draw reads them. The block takes one item every cycle
// while rsp_ready is high; a draw's pixel is valid on rsp_ after the range-check stage
// and the multiply stage followed by the three chained table rams, each with a registered
// read. Back-pressure on rsp_ fills the pipe bubble by bubble before req_ready drops.
// center_row (reset 100) is written on csr_ at any time, ready always high, and takes
// effect for items accepted after the write; change it only while the pipe is empty.
`default_nettype none

module column_texel_remap_pixel
   import ctrp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_valid,
   output logic         csr_ready,
   input  wire logic [7:0] csr_data
);

   logic [7:0]   center_row_ff, center_row_in;
   logic         tex_valid, tex_ready;
   tex_item_type tex_data;

   assign csr_ready     = 1'b1;
   assign center_row_in = (csr_valid && csr_ready) ? csr_data : center_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_row_ff <= CENTER_ROW_RESET;
      end else begin
         center_row_ff <= center_row_in;
      end
   end

   ctrp_coord u_coord (
      .clock      (clock),
      .reset      (reset),
      .center_row (center_row_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_data    (req_data),
      .out_valid  (tex_valid),
      .out_ready  (tex_ready),
      .out_data   (tex_data)
   );

   ctrp_lookup u_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (tex_valid),
      .in_ready  (tex_ready),
      .in_data   (tex_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
